[hw/rtl/cpsd_pkg.sv]
package cpsd_pkg;

   localparam int CPSD_CURRENT_BITS = 16;
   localparam int CPSD_MAG_BITS     = 16;
   localparam int CPSD_TIME_BITS    = 32;
   localparam int CPSD_CSR_IDX_BITS = 2;
   localparam int CPSD_CSR_DATA_BITS = 32;

   localparam logic [CPSD_MAG_BITS-1:0]  CPSD_THRESHOLD_RESET = 16'd1200;
   localparam logic [CPSD_TIME_BITS-1:0] CPSD_STALL_TIME_RESET = 32'd300;

   typedef enum logic [1:0] {
      KIND_SAMPLE      = 2'd0,
      KIND_EVALUATE    = 2'd1,
      KIND_STALL_RESET = 2'd2
   } kind_type;

   typedef enum logic [CPSD_CSR_IDX_BITS-1:0] {
      CSR_STALL_THRESHOLD = 2'd0,
      CSR_STALL_TIME      = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic sq_first;
      logic sq_second;
      logic root_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic in_is_sample;
   } dp_status_type;

endpackage

[hw/rtl/cpsd_channels.sv]
interface cpsd_req_if
   import cpsd_pkg::*;
#(
   parameter int CURRENT_BITS = CPSD_CURRENT_BITS
);
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic signed [CURRENT_BITS-1:0] phase_a_ma;
   logic signed [CURRENT_BITS-1:0] phase_b_ma;
   logic [CPSD_TIME_BITS-1:0] now_ms;

   modport source (output valid, kind, phase_a_ma, phase_b_ma, now_ms, input ready);
   modport sink (input valid, kind, phase_a_ma, phase_b_ma, now_ms, output ready);
endinterface

interface cpsd_rsp_if
   import cpsd_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CPSD_MAG_BITS-1:0] magnitude_ma;
   logic [CPSD_MAG_BITS-1:0] peak_ma;
   logic                     stall_active;
   logic                     stall_event;
   logic                     cleared_event;

   modport source (output valid, magnitude_ma, peak_ma, stall_active, stall_event,
                   cleared_event, input ready);
   modport sink (input valid, magnitude_ma, peak_ma, stall_active, stall_event,
                 cleared_event, output ready);
endinterface

[hw/rtl/cpsd_controller.sv]
module cpsd_controller
   import cpsd_pkg::*;
#(
   parameter int CURRENT_BITS = CPSD_CURRENT_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CNT_W = $clog2(CURRENT_BITS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQA  = 5'b00010,
      ST_SQB  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.in_is_sample ? ST_SQA : ST_DONE;
            end
         end
         ST_SQA: begin
            state_in = ST_SQB;
         end
         ST_SQB: begin
            state_in = ST_ROOT;
            cnt_in   = '0;
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(CURRENT_BITS - 1)) begin
               state_in = ST_DONE;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cmd.load      = accept;
      cmd.sq_first  = (state_ff == ST_SQA);
      cmd.sq_second = (state_ff == ST_SQB);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.commit    = commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/cpsd_datapath.sv]
module cpsd_datapath
   import cpsd_pkg::*;
#(
   parameter int CURRENT_BITS = CPSD_CURRENT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   input  logic [1:0]                     req_kind,
   input  logic signed [CURRENT_BITS-1:0] req_phase_a_ma,
   input  logic signed [CURRENT_BITS-1:0] req_phase_b_ma,
   input  logic [CPSD_TIME_BITS-1:0]      req_now_ms,
   input  logic                           csr_write_en,
   input  logic [CPSD_CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CPSD_CSR_DATA_BITS-1:0]  csr_wdata,
   output logic [CPSD_MAG_BITS-1:0]       rsp_magnitude_ma,
   output logic [CPSD_MAG_BITS-1:0]       rsp_peak_ma,
   output logic                           rsp_stall_active,
   output logic                           rsp_stall_event,
   output logic                           rsp_cleared_event
);

   localparam int CB  = CURRENT_BITS;
   localparam int SQW = 2 * CURRENT_BITS;
   localparam int RMW = CURRENT_BITS + 2;
   localparam int EXW = (CURRENT_BITS > CPSD_MAG_BITS) ? CURRENT_BITS : CPSD_MAG_BITS;
   localparam logic [EXW-1:0] MAG_MAX = EXW'({CPSD_MAG_BITS{1'b1}});

   logic [1:0]                kind_ff;
   logic [CB-1:0]             abs_a_ff, abs_b_ff;
   logic [CPSD_TIME_BITS-1:0] now_ff;
   logic [SQW-1:0]            acc_ff;
   logic [RMW-1:0]            rem_ff;
   logic [CB-1:0]             root_ff;

   logic [CPSD_MAG_BITS-1:0]  thr_ff;
   logic [CPSD_TIME_BITS-1:0] stall_time_ff;
   logic [CPSD_MAG_BITS-1:0]  peak_ff, peak_in;
   logic                      timing_ff, timing_in;
   logic [CPSD_TIME_BITS-1:0] since_ff, since_in;
   logic                      latch_ff, latch_in;

   logic [CPSD_MAG_BITS-1:0]  mag_ff, mag_out;
   logic [CPSD_MAG_BITS-1:0]  peak_out_ff, peak_out;
   logic                      active_ff;
   logic                      sev_ff, sev_out;
   logic                      cev_ff, cev_out;

   logic [CB-1:0]             abs_a_in, abs_b_in;
   logic [CB-1:0]             mul_op;
   logic [SQW-1:0]            prod;
   logic [RMW-1:0]            rem_shift, trial, rem_in;
   logic                      ge;
   logic [EXW-1:0]            root_ext;
   logic [CPSD_MAG_BITS-1:0]  mag_sat;
   logic [CPSD_TIME_BITS-1:0] elapsed;

   assign status.in_is_sample = (kind_type'(req_kind) == KIND_SAMPLE);

   assign abs_a_in = req_phase_a_ma[CB-1] ? CB'(-req_phase_a_ma) : CB'(req_phase_a_ma);
   assign abs_b_in = req_phase_b_ma[CB-1] ? CB'(-req_phase_b_ma) : CB'(req_phase_b_ma);

   assign mul_op = cmd.sq_second ? abs_b_ff : abs_a_ff;
   assign prod   = SQW'(mul_op) * SQW'(mul_op);

   assign rem_shift = {rem_ff[CB-1:0], acc_ff[SQW-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign ge        = (rem_shift >= trial);
   assign rem_in    = ge ? (rem_shift - trial) : rem_shift;

   assign root_ext = EXW'(root_ff);
   assign mag_sat  = (root_ext > MAG_MAX) ? {CPSD_MAG_BITS{1'b1}}
                                          : root_ext[CPSD_MAG_BITS-1:0];
   assign elapsed  = now_ff - since_ff;

   always_comb begin
      peak_in   = peak_ff;
      timing_in = timing_ff;
      since_in  = since_ff;
      latch_in  = latch_ff;
      mag_out   = '0;
      peak_out  = peak_ff;
      sev_out   = 1'b0;
      cev_out   = 1'b0;
      unique case (kind_ff)
         KIND_SAMPLE: begin
            mag_out = mag_sat;
            if (mag_sat > peak_ff) begin
               peak_in = mag_sat;
            end
            peak_out = peak_in;
         end
         KIND_EVALUATE: begin
            peak_in = '0;
            if (!latch_ff) begin
               priority if (peak_ff < thr_ff) begin
                  timing_in = 1'b0;
                  since_in  = '0;
               end else if (!timing_ff) begin
                  timing_in = 1'b1;
                  since_in  = now_ff;
               end else begin
                  if (elapsed >= stall_time_ff) begin
                     latch_in = 1'b1;
                     sev_out  = 1'b1;
                  end
               end
            end
         end
         KIND_STALL_RESET: begin
            cev_out   = latch_ff;
            timing_in = 1'b0;
            since_in  = '0;
            latch_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         abs_a_ff <= abs_a_in;
         abs_b_ff <= abs_b_in;
         now_ff   <= req_now_ms;
      end
      if (cmd.sq_first) begin
         acc_ff  <= prod;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sq_second) begin
         acc_ff <= acc_ff + prod;
      end else if (cmd.root_step) begin
         acc_ff  <= {acc_ff[SQW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[CB-2:0], ge};
      end
      if (cmd.commit) begin
         mag_ff      <= mag_out;
         peak_out_ff <= peak_out;
         active_ff   <= latch_in;
         sev_ff      <= sev_out;
         cev_ff      <= cev_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= CPSD_THRESHOLD_RESET;
         stall_time_ff <= CPSD_STALL_TIME_RESET;
         peak_ff       <= '0;
         timing_ff     <= 1'b0;
         since_ff      <= '0;
         latch_ff      <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_STALL_THRESHOLD) begin
            thr_ff <= csr_wdata[CPSD_MAG_BITS-1:0];
         end
         if (csr_write_en && csr_index == CSR_STALL_TIME) begin
            stall_time_ff <= csr_wdata[CPSD_TIME_BITS-1:0];
         end
         if (cmd.commit) begin
            peak_ff   <= peak_in;
            timing_ff <= timing_in;
            since_ff  <= since_in;
            latch_ff  <= latch_in;
         end
      end
   end

   assign rsp_magnitude_ma  = mag_ff;
   assign rsp_peak_ma       = peak_out_ff;
   assign rsp_stall_active  = active_ff;
   assign rsp_stall_event   = sev_ff;
   assign rsp_cleared_event = cev_ff;

endmodule

[hw/rtl/current_peak_stall_detector_top.sv]
// Channel    | Direction | Transfer contents
// -----------+-----------+------------------------------------------------------
// req_bus    | in        | kind, phase_a_ma, phase_b_ma, now_ms
// rsp_bus    | out       | magnitude_ma, peak_ma, stall_active, stall_event,
//            |           | cleared_event
// csr_*      | in        | write enable, register index, write data
//
// A current sample's magnitude comes from the square root, which yields one result bit
// per cycle, after both phases are squared in turn on the shared squaring multiplier.
// Evaluate, stall reset and unused kinds skip the squaring and the square root.
// Reset is synchronous and active high; it restores the register defaults and clears
// the peak hold, the timing and the latch.
// The next request is taken while a result still waits in the output register; a
// stalled output holds the finished item back only once a second one is complete.
module current_peak_stall_detector_top
   import cpsd_pkg::*;
#(
   parameter int CURRENT_BITS = CPSD_CURRENT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   cpsd_req_if.sink                      req_bus,
   cpsd_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_en,
   input  logic [CPSD_CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CPSD_CSR_DATA_BITS-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cpsd_controller #(
      .CURRENT_BITS(CURRENT_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .status   (status),
      .cmd      (cmd)
   );

   cpsd_datapath #(
      .CURRENT_BITS(CURRENT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_bus.kind),
      .req_phase_a_ma   (req_bus.phase_a_ma),
      .req_phase_b_ma   (req_bus.phase_b_ma),
      .req_now_ms       (req_bus.now_ms),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_magnitude_ma (rsp_bus.magnitude_ma),
      .rsp_peak_ma      (rsp_bus.peak_ma),
      .rsp_stall_active (rsp_bus.stall_active),
      .rsp_stall_event  (rsp_bus.stall_event),
      .rsp_cleared_event(rsp_bus.cleared_event)
   );

endmodule

[hw/rtl/cpsd_checker.sv]
module cpsd_checker
   import cpsd_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CPSD_MAG_BITS-1:0] rsp_magnitude_ma,
   input logic [CPSD_MAG_BITS-1:0] rsp_peak_ma,
   input logic                     rsp_stall_active,
   input logic                     rsp_stall_event,
   input logic                     rsp_cleared_event
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result withdrawn before its transfer.");

   a_event_sets_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall_event |-> rsp_stall_active)
      else $error("Stall event reported without the latch set.");

   a_clear_drops_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cleared_event |-> !rsp_stall_active && !rsp_stall_event)
      else $error("Cleared event reported with the latch still set.");

   a_peak_covers_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_ma >= rsp_magnitude_ma)
      else $error("Peak reported below the sample magnitude.");

endmodule

bind current_peak_stall_detector_top cpsd_checker u_cpsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_magnitude_ma (rsp_bus.magnitude_ma),
   .rsp_peak_ma      (rsp_bus.peak_ma),
   .rsp_stall_active (rsp_bus.stall_active),
   .rsp_stall_event  (rsp_bus.stall_event),
   .rsp_cleared_event(rsp_bus.cleared_event)
);
